FILE: hw/rtl/brpp_pkg.sv
// ----------------------------------------------------------------------------
// brpp_pkg: shared types and constants of the burst rate packet pacer
// Status codes, command codes, register indexes and saturating helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package brpp_pkg;

	// Width of every fixed-point time and wait kept in state
	localparam int TIME_W   = 64;
	// Whole-nanosecond time at the ports
	localparam int NS_W     = 48;
	// Fraction bits of wait_per_byte at the port
	localparam int WPB_FRAC = 16;
	localparam int BYTES_W  = 25;
	localparam int PKT_W    = 16;
	localparam int WPB_W    = 32;
	localparam int BSIZE_W  = 24;
	localparam int INV_W    = 17;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	localparam logic [BYTES_W-1:0] BYTES_MAX = '1;

	typedef logic [TIME_W-1:0] time_fx_t;

	typedef enum logic [1:0] {
		ST_SEND     = 2'd0,
		ST_SLEEP    = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_BACKDATE = 2'd3
	} status_t;

	localparam logic CMD_REQUEST  = 1'b0;
	localparam logic CMD_BACKDATE = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_BURST_SIZE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BURST_INV    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RATE_BY_HW   = 2'd2;

	localparam logic [BSIZE_W-1:0] BURST_SIZE_RESET = 24'd65536;
	localparam logic [INV_W-1:0]   BURST_INV_RESET  = 17'd65536;

	// Add, clamp at all ones on carry out
	function automatic time_fx_t sat_add(input time_fx_t a, input time_fx_t b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_W] ? '1 : s[TIME_W-1:0];
	endfunction

	function automatic time_fx_t max_fx(input time_fx_t a, input time_fx_t b);
		return (a > b) ? a : b;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/burst_rate_packet_pacer_core.sv
// Path: an accepted item passes the input register, then the result register.
// Throughput: one item per cycle while out_stall is low; each item's pacing step reads and
//   writes the pacing state between the input register and the result register.
// Reset (arst_n low, asynchronous): pacing state cleared to zero, registers to their
//   defaults (burst size 65536, inverse 65536, hardware pacing off), both stages empty.
// ----------------------------------------------------------------------------
// burst_rate_packet_pacer_core
// Token-bucket packet pacer kept as send times. Each request admits the waiting
// packet, asks the caller to sleep until a wake time, or reports an empty queue;
// a backdate command pulls the nominal send time up to now minus the owed wait.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module burst_rate_packet_pacer_core
	import brpp_pkg::*;
#(
	parameter int TIME_FRACTION_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	// configuration write channel
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,

	// request items
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic                  command,
	input  wire logic [NS_W-1:0]       now,
	input  wire logic                  packet_ready,
	input  wire logic [PKT_W-1:0]      packet_bytes,
	input  wire logic [WPB_W-1:0]      byte_wait,

	// result items
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [1:0]                 status,
	output logic [NS_W-1:0]            wake_time
);

	localparam int F = TIME_FRACTION_BITS;
	// Shift from the port's 16 fraction bits to the internal fraction width
	localparam int WPB_SHL = (F >= WPB_FRAC) ? F - WPB_FRAC : 0;
	localparam int WPB_SHR = (F <  WPB_FRAC) ? WPB_FRAC - F : 0;
	// A whole-ns value with any bit at or above this position overflows when shifted up
	localparam int NS_SAT_POS = TIME_W - F;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [BSIZE_W-1:0] burst_size_q;
	logic [INV_W-1:0]   burst_rate_inverse_q;
	logic               rate_by_hardware_q;

	// Writes are to arrive only while the pacer is idle; the block does not enforce this and always takes them.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_size_q         <= BURST_SIZE_RESET;
			burst_rate_inverse_q <= BURST_INV_RESET;
			rate_by_hardware_q   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_BURST_SIZE: burst_size_q         <= cfg_data[BSIZE_W-1:0];
				CFG_BURST_INV:  burst_rate_inverse_q <= cfg_data[INV_W-1:0];
				CFG_RATE_BY_HW: rate_by_hardware_q   <= cfg_data[0];
				default: ; // unmapped index: drop the write
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Input register (stage 1) and stage handshake
	// ------------------------------------------------------------------
	logic              valid_s1;
	logic              command_s1;
	logic [NS_W-1:0]   now_s1;
	logic              packet_ready_s1;
	logic [PKT_W-1:0]  packet_bytes_s1;
	logic [WPB_W-1:0]  byte_wait_s1;

	logic              out_valid_q;
	status_t           status_q;
	logic [NS_W-1:0]   wake_time_q;

	logic              s1_adv;   // stage 1 may move into the result register
	logic              step_en;  // the item in stage 1 is applied to the state

	// The result register frees up when empty or when its item is taken.
	assign s1_adv   = !out_valid_q || !out_stall;
	assign step_en  = valid_s1 && s1_adv;
	assign in_stall = valid_s1 && !s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			command_s1      <= command;
			now_s1          <= now;
			packet_ready_s1 <= packet_ready;
			packet_bytes_s1 <= packet_bytes;
			byte_wait_s1    <= byte_wait;
		end
	end

	// ------------------------------------------------------------------
	// Pacing state
	// ------------------------------------------------------------------
	time_fx_t           nominal_send_time_q;
	time_fx_t           burst_send_time_q;
	time_fx_t           owed_wait_q;
	logic [BYTES_W-1:0] bytes_in_burst_q;
	logic               sleeping_q;

	// ------------------------------------------------------------------
	// Pacing step: one pass of combinational logic per item
	// ------------------------------------------------------------------
	time_fx_t           now64;
	time_fx_t           now_fx;
	time_fx_t           owed_ns;
	time_fx_t           back_ns;
	time_fx_t           back_fx;
	logic               hold_sleep;
	logic               recalc;
	logic [TIME_W:0]    scale_hi;
	logic [INV_W+15:0]  scale_lo;
	time_fx_t           scaled_wait;
	time_fx_t           burst_add;
	time_fx_t           nominal_add;
	time_fx_t           target;
	time_fx_t           burst_rc;
	logic               slept;
	logic [BYTES_W-1:0] bytes_base;
	time_fx_t           owed_base;
	logic [PKT_W+WPB_W-1:0] wait_prod;
	time_fx_t           wait_fx;
	logic [BYTES_W:0]   bytes_sum;
	logic [BYTES_W-1:0] bytes_acc;
	time_fx_t           owed_acc;

	time_fx_t           nominal_nx;
	time_fx_t           burst_nx;
	time_fx_t           owed_nx;
	logic [BYTES_W-1:0] bytes_nx;
	logic               sleeping_nx;
	status_t            status_nx;
	time_fx_t           burst_ns_nx;

	// Time conversions and the sleep test on the held wake time
	always_comb begin
		now64   = {{(TIME_W-NS_W){1'b0}}, now_s1};
		now_fx  = ((now64 >> NS_SAT_POS) != '0) ? '1 : (now64 << F);
		owed_ns = owed_wait_q >> F;
		back_ns = (now64 > owed_ns) ? now64 - owed_ns : '0;
		back_fx = ((back_ns >> NS_SAT_POS) != '0) ? '1 : (back_ns << F);
		hold_sleep = sleeping_q && (now64 < (burst_send_time_q >> F));
		recalc     = bytes_in_burst_q >= {1'b0, burst_size_q};
	end

	// Burst recalculation: scale owed wait by the inverse ratio, advance both send times
	always_comb begin
		scale_hi = {{(INV_W){1'b0}}, owed_wait_q[TIME_W-1:16]}
			* {{(TIME_W-16){1'b0}}, burst_rate_inverse_q};
		scale_lo = {{(INV_W){1'b0}}, owed_wait_q[15:0]}
			* {16'b0, burst_rate_inverse_q};
		scaled_wait = scale_hi[TIME_W] ? '1 :
			sat_add(scale_hi[TIME_W-1:0],
				{{(TIME_W-INV_W){1'b0}}, scale_lo[INV_W+15:16]});
		burst_add   = sat_add(burst_send_time_q, scaled_wait);
		nominal_add = sat_add(nominal_send_time_q, owed_wait_q);
		target      = max_fx(burst_add, nominal_add);
		burst_rc    = max_fx(now_fx, target);
		slept       = now64 < (target >> F);
	end

	// Accumulation of the admitted packet's bytes and wait
	always_comb begin
		bytes_base = recalc ? '0 : bytes_in_burst_q;
		owed_base  = recalc ? '0 : owed_wait_q;
		wait_prod  = {{(WPB_W){1'b0}}, packet_bytes_s1} * {{(PKT_W){1'b0}}, byte_wait_s1};
		wait_fx    = ({{(TIME_W-PKT_W-WPB_W){1'b0}}, wait_prod} << WPB_SHL) >> WPB_SHR;
		bytes_sum  = {1'b0, bytes_base} + {{(BYTES_W+1-PKT_W){1'b0}}, packet_bytes_s1};
		bytes_acc  = bytes_sum[BYTES_W] ? BYTES_MAX : bytes_sum[BYTES_W-1:0];
		owed_acc   = sat_add(owed_base, wait_fx);
	end

	// Decision and next state
	always_comb begin
		nominal_nx  = nominal_send_time_q;
		burst_nx    = burst_send_time_q;
		owed_nx     = owed_wait_q;
		bytes_nx    = bytes_in_burst_q;
		sleeping_nx = sleeping_q;
		status_nx   = ST_SEND;
		if (command_s1 == CMD_BACKDATE) begin
			// never move the nominal send time earlier; leave sleeping as is
			nominal_nx = max_fx(back_fx, nominal_send_time_q);
			status_nx  = ST_BACKDATE;
		end else if (hold_sleep) begin
			status_nx = ST_SLEEP;
		end else begin
			sleeping_nx = 1'b0;
			if (recalc) begin
				burst_nx   = burst_rc;
				nominal_nx = nominal_add;
				bytes_nx   = '0;
				owed_nx    = '0;
				if (slept) begin
					sleeping_nx = 1'b1;
					status_nx   = ST_SLEEP;
				end
			end
			if (!(recalc && slept)) begin
				if (!packet_ready_s1) begin
					status_nx = ST_EMPTY;
				end else begin
					if (!rate_by_hardware_q) begin
						bytes_nx = bytes_acc;
						owed_nx  = owed_acc;
					end
					status_nx = ST_SEND;
				end
			end
		end
		burst_ns_nx = burst_nx >> F;
	end

	// Commit the step: hold the state unless an item leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nominal_send_time_q <= '0;
			burst_send_time_q   <= '0;
			owed_wait_q         <= '0;
			bytes_in_burst_q    <= '0;
			sleeping_q          <= 1'b0;
		end else if (step_en) begin
			nominal_send_time_q <= nominal_nx;
			burst_send_time_q   <= burst_nx;
			owed_wait_q         <= owed_nx;
			bytes_in_burst_q    <= bytes_nx;
			sleeping_q          <= sleeping_nx;
		end
	end

	// ------------------------------------------------------------------
	// Result register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			status_q    <= status_nx;
			wake_time_q <= burst_ns_nx[NS_W-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign wake_time = wake_time_q;

`ifndef SYNTHESIS
	// While asleep, the burst just closed: nothing is owed or counted.
	a_sleep_clean: assert property (@(posedge clk) disable iff (!arst_n)
		sleeping_q |-> (bytes_in_burst_q == '0 && owed_wait_q == '0))
		else $error("pacer asleep with bytes or wait still accumulated");

	// The nominal send time only moves forward.
	a_nominal_mono: assert property (@(posedge clk) disable iff (!arst_n)
		step_en |=> nominal_send_time_q >= $past(nominal_send_time_q))
		else $error("nominal send time moved backwards");

	// A recalculation clamps the burst send time to no earlier than now.
	a_burst_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && command_s1 == CMD_REQUEST && !hold_sleep && recalc)
		|=> burst_send_time_q >= $past(now_fx))
		else $error("burst send time left earlier than now");

	// With hardware pacing, owed wait never grows.
	a_hw_no_owe: assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && rate_by_hardware_q) |=> owed_wait_q <= $past(owed_wait_q))
		else $error("owed wait accumulated under hardware pacing");

	// An item leaving stage 1 always lands in the result register.
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		step_en |=> out_valid_q)
		else $error("stage 1 item lost on its way to the result register");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/tb_burst_rate_packet_pacer_core.sv
// ----------------------------------------------------------------------------
// tb_burst_rate_packet_pacer_core: self-checking bench for the packet pacer
// Feeds pacing requests and backdate commands through the request channel,
// keeps its own copy of the pacing state to predict status and wake time,
// and checks each result item in order while both sides idle and stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_burst_rate_packet_pacer_core
	import brpp_pkg::*;
();

	localparam int FRAC_BITS = 16;
	localparam int UP_SHIFT = (FRAC_BITS >= WPB_FRAC) ? FRAC_BITS - WPB_FRAC : 0;
	localparam int DOWN_SHIFT = (FRAC_BITS < WPB_FRAC) ? WPB_FRAC - FRAC_BITS : 0;
	localparam int RUN_LIMIT = 400000;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int IDLE_PERCENT = 17;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS = 250;
	// index 3 is not a register: a write there must change nothing
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;
	localparam logic [NS_W-1:0] NS_MAX = '1;
	localparam logic [NS_W-1:0] T_MID = 48'h2_0000_0000;

	typedef struct packed {
		logic              command;
		logic [NS_W-1:0]   now;
		logic              packet_ready;
		logic [PKT_W-1:0]  packet_bytes;
		logic [WPB_W-1:0]  byte_wait;
	} pace_request_t;

	typedef struct packed {
		status_t           status;
		logic [NS_W-1:0]   wake_time;
	} pace_result_t;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	pace_request_t          offered = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [1:0]             status;
	logic [NS_W-1:0]        wake_time;

	// Register copies, at their reset defaults
	logic [BSIZE_W-1:0]     burst_size_cfg = BURST_SIZE_RESET;
	logic [INV_W-1:0]       burst_inverse_cfg = BURST_INV_RESET;
	logic                   hw_paced_cfg = 1'b0;

	// Pacing state copy, all clear after reset
	time_fx_t               nominal_fx = '0;
	time_fx_t               burst_fx = '0;
	time_fx_t               owed_fx = '0;
	logic [BYTES_W-1:0]     burst_bytes = '0;
	logic                   asleep = 1'b0;

	pace_request_t          pending_requests[$];
	pace_result_t           expected_results[$];
	pace_result_t           oldest;
	int unsigned            mismatch_count = 0;
	int unsigned            cycle_count = 0;
	int unsigned            holds_requested = 0;
	int unsigned            holds_served = 0;
	int unsigned            hold_left = 0;
	logic                   no_idle = 1'b0;
	// Time base of well-formed traffic; starts high so that earlier times
	// can be thrown in as noise without ever running past the send times
	logic [NS_W-1:0]        stim_now;

	burst_rate_packet_pacer_core #(
		.TIME_FRACTION_BITS(FRAC_BITS)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (offered.command),
		.now          (offered.now),
		.packet_ready (offered.packet_ready),
		.packet_bytes (offered.packet_bytes),
		.byte_wait    (offered.byte_wait),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.wake_time    (wake_time)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Fixed-point helpers of the predictor
	// ------------------------------------------------------------------

	// Add two fixed-point times, clamp at all ones
	function automatic time_fx_t add_clamped(input time_fx_t a, input time_fx_t b);
		logic [TIME_W:0] total;
		total = {1'b0, a} + {1'b0, b};
		return total[TIME_W] ? '1 : total[TIME_W-1:0];
	endfunction

	// Whole nanoseconds to fixed point, clamp when the shift would overflow
	function automatic time_fx_t ns_in_fixed(input logic [TIME_W-1:0] ns);
		if (ns > ({TIME_W{1'b1}} >> FRAC_BITS))
			return '1;
		return ns << FRAC_BITS;
	endfunction

	// Port wait (16 fraction bits) to the state's fraction width
	function automatic time_fx_t wait_in_fixed(input logic [TIME_W-1:0] q16);
		if (FRAC_BITS >= WPB_FRAC) begin
			if (q16 > ({TIME_W{1'b1}} >> UP_SHIFT))
				return '1;
			return q16 << UP_SHIFT;
		end
		return q16 >> DOWN_SHIFT;
	endfunction

	// floor(wait * inverse / 65536), clamped; the full product cannot wrap
	function automatic time_fx_t scaled_wait(input time_fx_t w, input logic [INV_W-1:0] inv);
		logic [TIME_W+INV_W-1:0] product;
		product = {{INV_W{1'b0}}, w} * {{TIME_W{1'b0}}, inv};
		product = product >> 16;
		return (product[TIME_W+INV_W-1:TIME_W] != '0) ? '1 : product[TIME_W-1:0];
	endfunction

	// ------------------------------------------------------------------
	// Predictor: one pacing decision, updates the state copy
	// ------------------------------------------------------------------
	function automatic pace_result_t pace_request(input pace_request_t rq);
		pace_result_t       res;
		logic [TIME_W-1:0]  owed_ns;
		logic [TIME_W-1:0]  back_ns;
		time_fx_t           back_fx;
		time_fx_t           now_fx;
		time_fx_t           target;
		logic [BYTES_W:0]   byte_sum;
		logic [TIME_W-1:0]  wait_q16;
		logic               slept;

		res.status = ST_SEND;
		if (rq.command == CMD_BACKDATE) begin
			// Pull nominal send time up to now minus owed wait, never down
			owed_ns = owed_fx >> FRAC_BITS;
			back_ns = (rq.now > owed_ns) ? rq.now - owed_ns : '0;
			back_fx = ns_in_fixed(back_ns);
			if (back_fx > nominal_fx)
				nominal_fx = back_fx;
			res.status = ST_BACKDATE;
		end else if (asleep && rq.now < (burst_fx >> FRAC_BITS)) begin
			res.status = ST_SLEEP;
		end else begin
			slept = 1'b0;
			asleep = 1'b0;
			if (burst_bytes >= burst_size_cfg) begin
				// Burst complete: settle owed wait into both send times
				now_fx = ns_in_fixed(TIME_W'(rq.now));
				burst_fx = add_clamped(burst_fx, scaled_wait(owed_fx, burst_inverse_cfg));
				nominal_fx = add_clamped(nominal_fx, owed_fx);
				burst_bytes = '0;
				owed_fx = '0;
				target = (burst_fx > nominal_fx) ? burst_fx : nominal_fx;
				burst_fx = (now_fx > target) ? now_fx : target;
				if (rq.now < (target >> FRAC_BITS)) begin
					asleep = 1'b1;
					slept = 1'b1;
					res.status = ST_SLEEP;
				end
			end
			if (!slept) begin
				if (!rq.packet_ready) begin
					res.status = ST_EMPTY;
				end else begin
					if (!hw_paced_cfg) begin
						byte_sum = {1'b0, burst_bytes} + (BYTES_W + 1)'(rq.packet_bytes);
						burst_bytes = byte_sum[BYTES_W] ? {BYTES_W{1'b1}} : byte_sum[BYTES_W-1:0];
						wait_q16 = TIME_W'(rq.packet_bytes) * TIME_W'(rq.byte_wait);
						owed_fx = add_clamped(owed_fx, wait_in_fixed(wait_q16));
					end
					res.status = ST_SEND;
				end
			end
		end
		res.wake_time = burst_fx[FRAC_BITS +: NS_W];
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("MISMATCH at %0t: %s", $realtime, what);
	endtask

	task automatic push_request(input logic cmd, input logic [NS_W-1:0] t, input logic ready,
			input logic [PKT_W-1:0] bytes, input logic [WPB_W-1:0] wpb);
		pace_request_t rq;
		rq.command = cmd;
		rq.now = t;
		rq.packet_ready = ready;
		rq.packet_bytes = bytes;
		rq.byte_wait = wpb;
		pending_requests.push_back(rq);
	endtask

	// Write one register; the block is idle whenever this is called
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_BURST_SIZE: burst_size_cfg = val[BSIZE_W-1:0];
			CFG_BURST_INV:  burst_inverse_cfg = val[INV_W-1:0];
			CFG_RATE_BY_HW: hw_paced_cfg = val[0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Hold until every queued item has gone in and every result has come out
	task automatic wait_drained();
		do @(negedge clk);
		while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0);
		repeat (3) @(negedge clk);
	endtask

	// Mostly a well-formed request stream on an advancing clock; the rest is
	// noise with every field but the time drawn over its whole range
	task automatic queue_random_item();
		pace_request_t rq;
		logic [63:0]   step;
		if ($urandom_range(99) < 85) begin
			// occasional long jump lets a deep sleep run out
			if ($urandom_range(99) < 4)
				step = 64'($urandom) << $urandom_range(2);
			else
				step = 64'($urandom_range(3000));
			stim_now = stim_now + step[NS_W-1:0];
			rq.command = ($urandom_range(99) < 6) ? CMD_BACKDATE : CMD_REQUEST;
			rq.now = stim_now;
			rq.packet_ready = ($urandom_range(99) >= 8);
			rq.packet_bytes = ($urandom_range(99) < 5) ? PKT_W'($urandom_range(65535))
				: PKT_W'($urandom_range(9000, 64));
			rq.byte_wait = $urandom_range(1 << 16, 1 << 10);
		end else begin
			rq.command = 1'($urandom_range(1));
			// never ahead of the stream, so no send time is pushed out of reach
			if ($urandom_range(1))
				rq.now = stim_now;
			else
				rq.now = NS_W'({$urandom, $urandom} % (64'(stim_now) + 64'd1));
			rq.packet_ready = 1'($urandom_range(1));
			rq.packet_bytes = PKT_W'($urandom_range(65535));
			rq.byte_wait = $urandom;
		end
		pending_requests.push_back(rq);
	endtask

	// ------------------------------------------------------------------
	// Request driver: advance on accept, idle at random
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			// Predict at the accepting edge, from the payload still on the port
			if (in_valid && !in_stall)
				expected_results.push_back(pace_request(offered));
			// Hold a stalled item; otherwise offer the next one or go idle
			if (!in_valid || !in_stall) begin
				if (pending_requests.size() != 0 &&
						(no_idle || $urandom_range(99) >= IDLE_PERCENT)) begin
					offered <= pending_requests[0];
					pending_requests.delete(0);
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result stall: random, or one long hold-off on request
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (holds_served != holds_requested) begin
			holds_served <= holds_served + 1;
			hold_left <= HOLD_OFF_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !no_idle && ($urandom_range(99) < IDLE_PERCENT);
		end
	end

	// ------------------------------------------------------------------
	// Result monitor: compare each accepted item with the oldest expectation
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result: status %0d wake_time %0h",
					status, wake_time));
			end else begin
				oldest = expected_results[0];
				expected_results.delete(0);
				if (status !== oldest.status)
					report_mismatch($sformatf("status %0d, want %0d (%s)",
						status, oldest.status, oldest.status.name()));
				if (wake_time !== oldest.wake_time)
					report_mismatch($sformatf("wake_time %0h, want %0h",
						wake_time, oldest.wake_time));
			end
		end
	end

	// Watchdog: drop the run if the flow ever hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == RUN_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		stim_now = {1'b1, 15'($urandom_range(32767) >> 1), 32'($urandom)};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed, default registers: empty queue, largest packet at the
		// largest wait, backdate that would go below zero, a burst that
		// forces a sleep, a request while asleep, a backdate while asleep
		// (sleep kept), then a wake at the top of the time range
		push_request(CMD_REQUEST, '0, 1'b0, '0, '0);
		push_request(CMD_REQUEST, 48'd1, 1'b1, '1, '1);
		push_request(CMD_BACKDATE, 48'd5, 1'b0, '0, '0);
		push_request(CMD_REQUEST, 48'd6, 1'b1, 16'd1, '0);
		push_request(CMD_REQUEST, 48'd7, 1'b1, 16'd100, 32'h0001_0000);
		push_request(CMD_REQUEST, 48'd8, 1'b1, 16'd100, 32'h0001_0000);
		push_request(CMD_BACKDATE, 48'd9, 1'b1, '1, '1);
		push_request(CMD_REQUEST, NS_MAX, 1'b1, '0, '0);
		wait_drained();

		// Zero burst size and zero inverse: recalculate on every request,
		// burst send time gains nothing from the owed wait
		write_reg(CFG_BURST_SIZE, '0);
		write_reg(CFG_BURST_INV, '0);
		push_request(CMD_REQUEST, T_MID, 1'b1, 16'd1000, 32'h0001_0000);
		push_request(CMD_REQUEST, T_MID + 1, 1'b1, 16'd1000, 32'h0001_0000);
		push_request(CMD_REQUEST, T_MID + 2, 1'b0, '0, '0);
		wait_drained();

		// Largest burst, inverse above ratio one, hardware pacing on
		write_reg(CFG_BURST_SIZE, {CFG_DATA_W{1'b1}});
		write_reg(CFG_BURST_INV, 24'd131071);
		write_reg(CFG_RATE_BY_HW, 24'd1);
		write_reg(CFG_SPARE_INDEX, CFG_DATA_W'($urandom));
		push_request(CMD_REQUEST, T_MID + 10, 1'b1, '1, '1);
		push_request(CMD_BACKDATE, T_MID + 11, 1'b1, '1, '1);
		wait_drained();

		// Short burst with scaled wait: sleep, then wake later
		write_reg(CFG_RATE_BY_HW, '0);
		write_reg(CFG_BURST_SIZE, 24'd100);
		push_request(CMD_REQUEST, T_MID + 12, 1'b1, 16'd5000, 32'h0010_0000);
		push_request(CMD_REQUEST, T_MID + 20, 1'b1, 16'd64, 32'h0001_0000);
		push_request(CMD_REQUEST, T_MID + 30, 1'b1, 16'd64, 32'h0001_0000);
		push_request(CMD_REQUEST, T_MID + 400000, 1'b0, 16'd64, 32'h0001_0000);
		wait_drained();

		// Random phases, each with its own register setting
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			write_reg(CFG_BURST_SIZE, (phase == 3) ? '0 : CFG_DATA_W'($urandom_range(30000, 1)));
			case (phase % 4)
				0: write_reg(CFG_BURST_INV, CFG_DATA_W'(BURST_INV_RESET));
				1: write_reg(CFG_BURST_INV, 24'd32768);
				2: write_reg(CFG_BURST_INV, CFG_DATA_W'($urandom_range(131071)));
				default: write_reg(CFG_BURST_INV, (phase == 7) ? '0 : 24'd98304);
			endcase
			write_reg(CFG_RATE_BY_HW, (phase == 6) ? 24'd1 : 24'd0);
			// one phase with no idling on either side
			no_idle = (phase == 2);
			for (int n = 0; n < PHASE_ITEMS; n++)
				queue_random_item();
			// long receiver hold-off while requests keep coming
			if (phase == 5)
				holds_requested++;
			wait_drained();
		end
		no_idle = 1'b0;

		// Top of the time range last, since it pushes the send times to the
		// end: saturating burst send time, backdate at the largest now and at zero
		write_reg(CFG_BURST_SIZE, '0);
		write_reg(CFG_BURST_INV, 24'd131071);
		push_request(CMD_REQUEST, NS_MAX, 1'b1, '1, '1);
		push_request(CMD_REQUEST, NS_MAX, 1'b1, '1, '1);
		push_request(CMD_BACKDATE, NS_MAX, 1'b0, '0, '0);
		push_request(CMD_BACKDATE, '0, 1'b0, '0, '0);
		push_request(CMD_REQUEST, NS_MAX, 1'b0, '0, '0);
		wait_drained();

		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
